// File: hdl/hfpa_pkg.sv
package hfpa_pkg;

    // Operation codes carried in the func field of an input word.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_STATUS = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    // Result kinds carried in the result_kind field of an output word.
    localparam logic [2:0] KIND_INSERTED     = 3'd0;
    localparam logic [2:0] KIND_REJECTED     = 3'd1;
    localparam logic [2:0] KIND_PAGE_COUNT   = 3'd2;
    localparam logic [2:0] KIND_PAGE_RECORDS = 3'd3;
    localparam logic [2:0] KIND_FOUND        = 3'd4;
    localparam logic [2:0] KIND_NOT_FOUND    = 3'd5;

    // Page layout.
    localparam logic [15:0] HEADER_BYTES      = 16'd16;
    localparam logic [16:0] SLOT_BYTES        = 17'd4;
    localparam logic [15:0] PAGE_SIZE_DEFAULT = 16'd4096;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        record_size;
        logic signed [31:0] record_value;
    } t_in;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [4:0] page_index;
        logic [5:0] slot_index;
        logic [6:0] count;
        logic       last;
    } t_out;

endpackage

// File: hdl/hfpa_ram.sv
module hfpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Simple dual-port RAM: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/heap_file_page_allocator_unit.sv
// First-fit page allocator. The block keeps a file of up to MAX_PAGES pages,
// each with room for MAX_SLOTS records, and serves three operations on its
// input words: insert (place a value in the first page with enough free bytes
// and a free slot, or open a new page, or reject), status (one word with the
// page count, then one word per open page with its record count) and search
// (page and slot of the first stored value equal to the one sought, in page
// then slot order). Every input word is answered by one result word, except a
// status, which yields one plus the number of open pages, and the unused
// operation code, which yields none; the final word of each answer carries
// last. Items are handled one at a time. The page table and the record values
// live in two RAMs with one read port each, and the scan walks them one entry
// per cycle. A result word waits in an output register, and the block stalls
// only when that register is still full. The page_size register may be written
// only while the block is idle; it affects pages opened afterwards.
module heap_file_page_allocator_unit #(
    parameter int MAX_PAGES = 32,
    parameter int MAX_SLOTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hfpa_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hfpa_pkg::t_out o_out,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data
);

    import hfpa_pkg::*;

    // Page index, page counter, slot index and record count widths.
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RW = $clog2(MAX_SLOTS + 1);
    localparam int VDEPTH = 1 << (PW + SW);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_INS_CHK  = 8'b00000010,
        S_INS_NEW  = 8'b00000100,
        S_STAT_HDR = 8'b00001000,
        S_STAT_PG  = 8'b00010000,
        S_SRC_PG   = 8'b00100000,
        S_SRC_VAL  = 8'b01000000,
        S_SRC_MISS = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_pages, n_pages;   // open pages
    logic [CW-1:0] r_p, n_p;           // page under scan
    logic [SW-1:0] r_s, n_s;           // slot under scan
    logic [RW-1:0] r_cnt, n_cnt;       // record count of the page being searched
    logic [15:0]   r_page_size;

    // Operands of the current item.
    logic [15:0] r_size;
    logic [31:0] r_value;

    logic r_out_valid;
    t_out r_out;

    // Page table RAM: {free bytes, record count} per page.
    logic               pg_we;
    logic [PW-1:0]      pg_waddr;
    logic [16+RW-1:0]   pg_wdata;
    logic [16+RW-1:0]   pg_rdata;
    logic [15:0]        rd_free;
    logic [RW-1:0]      rd_cnt;

    // Record value RAM, addressed by {page, slot}.
    logic               val_we;
    logic [PW+SW-1:0]   val_waddr;
    logic [31:0]        val_rdata;

    logic        accept;
    logic        out_free;
    logic        emit;
    t_out        e_out;
    logic [16:0] need;
    logic [15:0] empty_free;
    logic [CW-1:0] p_next;
    logic [RW-1:0] s_next;

    assign rd_free = pg_rdata[RW +: 16];
    assign rd_cnt  = pg_rdata[RW-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A record needs its payload plus one slot entry; a fresh page offers
    // the page size minus its header, or nothing if the page is too small.
    assign need       = {1'b0, r_size} + SLOT_BYTES;
    assign empty_free = (r_page_size >= HEADER_BYTES) ? (r_page_size - HEADER_BYTES) : 16'd0;
    assign p_next     = r_p + CW'(1);
    assign s_next     = RW'(r_s) + RW'(1);

    hfpa_ram #(
        .WIDTH(16 + RW),
        .DEPTH(MAX_PAGES)
    ) u_page_ram (
        .i_clk  (i_clk),
        .i_we   (pg_we),
        .i_waddr(pg_waddr),
        .i_wdata(pg_wdata),
        .i_raddr(n_p[PW-1:0]),
        .o_rdata(pg_rdata)
    );

    hfpa_ram #(
        .WIDTH(32),
        .DEPTH(VDEPTH)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(r_value),
        .i_raddr({n_p[PW-1:0], n_s}),
        .o_rdata(val_rdata)
    );

    // The read addresses follow the next scan position, so the registered
    // RAM data in any state always belongs to the current r_p and r_s. Writes
    // happen only on the last cycle of an insert, so no read can overlap a
    // pending write to the same entry.
    always_comb begin
        n_state   = r_state;
        n_pages   = r_pages;
        n_p       = r_p;
        n_s       = r_s;
        n_cnt     = r_cnt;
        emit      = 1'b0;
        e_out     = '0;
        e_out.last = 1'b1;
        pg_we     = 1'b0;
        pg_waddr  = r_p[PW-1:0];
        pg_wdata  = {rd_free - need[15:0], rd_cnt + RW'(1)};
        val_we    = 1'b0;
        val_waddr = {r_p[PW-1:0], rd_cnt[SW-1:0]};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_p = '0;
                    n_s = '0;
                    case (i_in.func)
                        FUNC_INSERT: n_state = (r_pages == '0) ? S_INS_NEW : S_INS_CHK;
                        FUNC_STATUS: n_state = S_STAT_HDR;
                        FUNC_SEARCH: n_state = (r_pages == '0) ? S_SRC_MISS : S_SRC_PG;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end

            S_INS_CHK: begin
                if (rd_cnt < RW'(MAX_SLOTS) && {1'b0, rd_free} >= need) begin
                    if (out_free) begin
                        pg_we              = 1'b1;
                        val_we             = 1'b1;
                        emit               = 1'b1;
                        e_out.result_kind  = KIND_INSERTED;
                        e_out.page_index   = 5'(r_p);
                        e_out.slot_index   = 6'(rd_cnt);
                        n_state            = S_IDLE;
                    end
                end else begin
                    n_p = p_next;
                    if (p_next == r_pages) begin
                        n_state = S_INS_NEW;
                    end
                end
            end

            S_INS_NEW: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_pages >= CW'(MAX_PAGES) || need > {1'b0, empty_free}) begin
                        e_out.result_kind = KIND_REJECTED;
                    end else begin
                        pg_we             = 1'b1;
                        pg_waddr          = r_pages[PW-1:0];
                        pg_wdata          = {empty_free - need[15:0], RW'(1)};
                        val_we            = 1'b1;
                        val_waddr         = {r_pages[PW-1:0], SW'(0)};
                        n_pages           = r_pages + CW'(1);
                        e_out.result_kind = KIND_INSERTED;
                        e_out.page_index  = 5'(r_pages);
                    end
                end
            end

            S_STAT_HDR: begin
                if (out_free) begin
                    emit              = 1'b1;
                    e_out.result_kind = KIND_PAGE_COUNT;
                    e_out.count       = 7'(r_pages);
                    e_out.last        = (r_pages == '0);
                    n_state           = (r_pages == '0) ? S_IDLE : S_STAT_PG;
                end
            end

            S_STAT_PG: begin
                if (out_free) begin
                    emit              = 1'b1;
                    e_out.result_kind = KIND_PAGE_RECORDS;
                    e_out.page_index  = 5'(r_p);
                    e_out.count       = 7'(rd_cnt);
                    e_out.last        = (p_next == r_pages);
                    n_p               = p_next;
                    if (p_next == r_pages) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_SRC_PG: begin
                n_cnt = rd_cnt;
                if (rd_cnt == '0) begin
                    n_p     = p_next;
                    n_state = (p_next == r_pages) ? S_SRC_MISS : S_SRC_PG;
                end else begin
                    n_s     = '0;
                    n_state = S_SRC_VAL;
                end
            end

            S_SRC_VAL: begin
                if (val_rdata == r_value) begin
                    if (out_free) begin
                        emit              = 1'b1;
                        e_out.result_kind = KIND_FOUND;
                        e_out.page_index  = 5'(r_p);
                        e_out.slot_index  = 6'(r_s);
                        n_state           = S_IDLE;
                    end
                end else if (s_next == r_cnt) begin
                    n_s     = '0;
                    n_p     = p_next;
                    n_state = (p_next == r_pages) ? S_SRC_MISS : S_SRC_PG;
                end else begin
                    n_s = SW'(s_next);
                end
            end

            S_SRC_MISS: begin
                if (out_free) begin
                    emit              = 1'b1;
                    e_out.result_kind = KIND_NOT_FOUND;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pages     <= '0;
            r_p         <= '0;
            r_s         <= '0;
            r_cnt       <= '0;
            r_page_size <= PAGE_SIZE_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pages <= n_pages;
            r_p     <= n_p;
            r_s     <= n_s;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_page_size <= i_cfg_wr_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size  <= i_in.record_size;
            r_value <= i_in.record_value;
        end
        if (emit) begin
            r_out <= e_out;
        end
    end

endmodule

// File: hdl/hfpa_checker.sv
module hfpa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input hfpa_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input hfpa_pkg::t_out o_out
);

    import hfpa_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // Any real operation takes the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.func == FUNC_INSERT || i_in.func == FUNC_STATUS ||
        i_in.func == FUNC_SEARCH) |=> !o_in_ready)
        else $error("input accepted again before the operation finished");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.result_kind <= KIND_NOT_FOUND)
        else $error("undefined result kind");

    // Rejections and misses carry no location and no count, and both end the answer.
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.result_kind == KIND_REJECTED ||
        o_out.result_kind == KIND_NOT_FOUND) |->
        o_out.page_index == '0 && o_out.slot_index == '0 && o_out.count == '0 && o_out.last)
        else $error("reject or miss word has nonzero fields");

    a_loc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.result_kind == KIND_INSERTED ||
        o_out.result_kind == KIND_FOUND) |-> o_out.count == '0 && o_out.last)
        else $error("insert or find word has a count or is not final");

endmodule

bind heap_file_page_allocator_unit hfpa_checker u_hfpa_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import hfpa_pkg::*;

    localparam int MAX_PAGES = 32;
    localparam int MAX_SLOTS = 64;

    // The block ignores the fourth operation code and answers it with nothing.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Cycles of quiet time after the last expected word before the page size
    // register is touched or the run ends. A word with the unused code may
    // still be in flight at that point.
    localparam int SETTLE_CYCLES = 64;

    // The clock, the reset and every input of the block start at known values.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    t_in         i_in          = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b1;
    t_out        o_out;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    always #1 i_clk = ~i_clk;

    heap_file_page_allocator_unit #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Our own picture of the heap file. It is updated at the clock edge at
    // which an input word is accepted, so it always matches the order in which
    // the block sees the words.
    logic [15:0] model_page_size = PAGE_SIZE_DEFAULT;
    int          model_pages     = 0;
    logic [15:0] model_free [MAX_PAGES];
    int          model_recs [MAX_PAGES];
    logic [31:0] model_vals [MAX_PAGES][MAX_SLOTS];

    // Result words the block still owes us, oldest first.
    t_out        expected_words[$];
    // Values that were stored, so that searches can aim at real records.
    logic [31:0] value_pool[$];

    int errors         = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int size_writes    = 0;
    int inserts_denied = 0;
    int searches_hit   = 0;

    // Sender pacing: words go out in bursts, with idle gaps in between when
    // gaps are enabled. The receiver stall pattern runs on its own below.
    bit gaps_on     = 1'b0;
    int burst_left  = 0;
    bit rx_stall_en = 1'b0;
    int rx_left     = 0;

    function automatic t_out make_word(input logic [2:0] kind, input int pg, input int sl,
                                       input int cnt, input bit fin);
        t_out w;
        w.result_kind = kind;
        w.page_index  = 5'(pg);
        w.slot_index  = 6'(sl);
        w.count       = 7'(cnt);
        w.last        = fin;
        return w;
    endfunction

    // Appends one word to the list of words the block owes.
    function automatic void owe_word(input t_out w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Puts a record into the next slot of a page and books the bytes it uses.
    function automatic void store_record(input int pg, input int need, input logic [31:0] val);
        int sl;
        sl = model_recs[pg];
        model_vals[pg][sl] = val;
        model_recs[pg] = sl + 1;
        model_free[pg] = 16'(int'(model_free[pg]) - need);
        value_pool.insert(value_pool.size(), val);
        owe_word(make_word(KIND_INSERTED, pg, sl, 0, 1'b1));
    endfunction

    // Works out every result word that one accepted input word causes and
    // queues them in order, updating the page table on the way.
    function automatic void predict_word(input logic [1:0] op, input logic [15:0] nbytes,
                                         input logic [31:0] val);
        int need;
        int empty_free;
        int pg;
        int sl;
        bit done;
        done = 1'b0;
        case (op)
            FUNC_INSERT: begin
                need = int'(nbytes) + int'(SLOT_BYTES);
                empty_free = (model_page_size >= HEADER_BYTES) ?
                             int'(model_page_size) - int'(HEADER_BYTES) : 0;
                // First fit: a page whose slot array is full is passed over
                // no matter how many bytes it still has.
                for (pg = 0; pg < model_pages && !done; pg++) begin
                    if (model_recs[pg] < MAX_SLOTS && int'(model_free[pg]) >= need) begin
                        store_record(pg, need, val);
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    if (model_pages >= MAX_PAGES || need > empty_free) begin
                        owe_word(make_word(KIND_REJECTED, 0, 0, 0, 1'b1));
                        inserts_denied++;
                    end else begin
                        model_free[model_pages] = 16'(empty_free);
                        model_recs[model_pages] = 0;
                        model_pages++;
                        store_record(model_pages - 1, need, val);
                    end
                end
            end
            FUNC_STATUS: begin
                owe_word(make_word(KIND_PAGE_COUNT, 0, 0, model_pages, model_pages == 0));
                for (pg = 0; pg < model_pages; pg++) begin
                    owe_word(make_word(KIND_PAGE_RECORDS, pg, 0, model_recs[pg],
                                       pg + 1 == model_pages));
                end
            end
            FUNC_SEARCH: begin
                for (pg = 0; pg < model_pages && !done; pg++) begin
                    for (sl = 0; sl < model_recs[pg] && !done; sl++) begin
                        if (model_vals[pg][sl] == val) begin
                            owe_word(make_word(KIND_FOUND, pg, sl, 0, 1'b1));
                            searches_hit++;
                            done = 1'b1;
                        end
                    end
                end
                if (!done) begin
                    owe_word(make_word(KIND_NOT_FOUND, 0, 0, 0, 1'b1));
                end
            end
            default: begin
                // The unused code leaves the state alone and owes no word.
            end
        endcase
    endfunction

    // Values lean toward a handful of small numbers so that searches see
    // duplicates and the first match matters, with the extremes mixed in.
    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 32'($urandom_range(0, 7)) - 32'd4;
        end else if (r < 45) begin
            return 32'h8000_0000;
        end else if (r < 50) begin
            return 32'h7fff_ffff;
        end
        return $urandom();
    endfunction

    // Presents one input word and holds it until the block takes it. A new
    // burst may be preceded by an idle gap.
    task automatic send_word(input logic [1:0] op, input logic [15:0] nbytes,
                             input logic [31:0] val);
        int gap;
        t_in w;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else if (burst_left != 0) begin
            burst_left--;
        end
        w.func         = op;
        w.record_size  = nbytes;
        w.record_value = val;
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_word(op, nbytes, val);
        words_sent++;
    endtask

    // Drops valid, then waits until every owed word has arrived and the block
    // has had time to finish anything that owes no word.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The page size register is only written while the block is idle.
    task automatic write_page_size(input logic [15:0] bytes_per_page);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bytes_per_page;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        model_page_size = bytes_per_page;
        size_writes++;
    endtask

    // A mix of mostly well-formed traffic: inserts sized around the given cap,
    // searches that mostly aim at stored values, status reports, and now and
    // then the unused code. Fields that an operation ignores stay random.
    task automatic random_traffic(input int n_words, input int size_cap);
        int unsigned r;
        logic [1:0]  op;
        logic [15:0] nbytes;
        logic [31:0] val;
        for (int k = 0; k < n_words; k++) begin
            r      = $urandom_range(0, 99);
            nbytes = 16'($urandom_range(0, 65535));
            val    = $urandom();
            if (r < 58) begin
                op = FUNC_INSERT;
                r  = $urandom_range(0, 9);
                if (r < 7) begin
                    nbytes = 16'($urandom_range(0, size_cap));
                end else if (r < 9) begin
                    nbytes = 16'($urandom_range(0, int'(model_page_size)));
                end
                val = pick_value();
            end else if (r < 88) begin
                op = FUNC_SEARCH;
                if (value_pool.size() != 0 && $urandom_range(0, 2) != 0) begin
                    val = value_pool[$urandom_range(0, value_pool.size() - 1)];
                end else begin
                    val = pick_value();
                end
            end else if (r < 97) begin
                op = FUNC_STATUS;
            end else begin
                op = FUNC_UNUSED;
            end
            send_word(op, nbytes, val);
        end
    endtask

    // An empty file right after reset: the status is a single word, a search
    // finds nothing, and the unused code is silent.
    task automatic test_empty_file();
        send_word(FUNC_STATUS, 16'h0000, 32'h0000_0000);
        send_word(FUNC_SEARCH, 16'h0000, 32'h0000_0000);
        send_word(FUNC_UNUSED, 16'hffff, 32'hffff_ffff);
    endtask

    // With the reset page size of 4096 an empty page has 4080 free bytes. The
    // first three pages are filled to the last byte, a record one byte too
    // large and the largest record are turned away, and duplicates show that
    // a search reports the first match.
    task automatic test_first_fit_limits();
        send_word(FUNC_INSERT, 16'd4076,  32'h7fff_ffff);
        send_word(FUNC_INSERT, 16'd65535, 32'h0000_0000);
        send_word(FUNC_INSERT, 16'd4077,  32'h0000_0001);
        send_word(FUNC_INSERT, 16'd0,     32'h8000_0000);
        send_word(FUNC_INSERT, 16'd4072,  32'h0000_0005);
        send_word(FUNC_INSERT, 16'd4076,  32'h7fff_ffff);
        send_word(FUNC_SEARCH, 16'hffff,  32'h7fff_ffff);
        send_word(FUNC_SEARCH, 16'd0,     32'h8000_0000);
        send_word(FUNC_SEARCH, 16'd0,     32'hffff_ffff);
        send_word(FUNC_STATUS, 16'h5a5a,  32'ha5a5_a5a5);
    endtask

    // The smallest page size leaves four free bytes, so only an empty record
    // fits and each one opens a page of its own. The full pages from before
    // keep their own byte counts.
    task automatic test_small_pages();
        write_page_size(16'd20);
        gaps_on = 1'b1;
        rx_stall_en <= 1'b1;
        random_traffic(24, 0);
    endtask

    // The largest page size makes the slot array the limit, so pages fill
    // up to the last slot and the scan has to skip them. The first stretch
    // runs with neither side idling.
    task automatic test_deep_pages();
        write_page_size(16'hffff);
        gaps_on = 1'b0;
        rx_stall_en <= 1'b0;
        random_traffic(60, 255);
        gaps_on = 1'b1;
        rx_stall_en <= 1'b1;
        random_traffic(100, 255);
    endtask

    // Several page sizes in turn, each with record sizes that suit it.
    task automatic test_mixed_page_sizes();
        int unsigned r;
        int          bytes_per_page;
        for (int k = 0; k < 4; k++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                bytes_per_page = 20 + $urandom_range(0, 200);
            end else if (r < 50) begin
                bytes_per_page = 4096;
            end else if (r < 75) begin
                bytes_per_page = $urandom_range(20, 65535);
            end else begin
                bytes_per_page = 1000;
            end
            write_page_size(16'(bytes_per_page));
            random_traffic(40, bytes_per_page / 4);
        end
    endtask

    // A record that exactly fills an empty page of the largest size fits in
    // no open page, since each of those already holds a record. Sending such
    // records opens pages until the table is full, and the next one is
    // turned away for lack of a page. A status then walks all 32 pages.
    task automatic test_full_table();
        write_page_size(16'hffff);
        gaps_on = 1'b0;
        for (int k = 0; k < MAX_PAGES + 4 && model_pages < MAX_PAGES; k++) begin
            send_word(FUNC_INSERT, 16'd65515, pick_value());
        end
        send_word(FUNC_INSERT, 16'd65515, pick_value());
        // Let everything drain before the long status report goes in.
        wait_for_results();
        gaps_on = 1'b1;
        send_word(FUNC_STATUS, 16'h0000, 32'h0000_0000);
        send_word(FUNC_SEARCH, 16'h0000, value_pool[value_pool.size() - 1]);
        send_word(FUNC_SEARCH, 16'h0000, $urandom());
        random_traffic(40, 64);
    endtask

    // The receiver runs its own pattern of ready and stalled stretches.
    always @(posedge i_clk) begin
        if (!rx_stall_en) begin
            i_out_ready <= 1'b1;
            rx_left     <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            rx_left     <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
            rx_left     <= $urandom_range(0, 9);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Every word the block hands over is held against the oldest one owed.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected, expected nothing, actual %p",
                         $time, o_out);
                errors++;
            end else begin
                want = expected_words.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(o_out.result_kind));
                check_field("page_index",  32'(want.page_index),  32'(o_out.page_index));
                check_field("slot_index",  32'(want.slot_index),  32'(o_out.slot_index));
                check_field("count",       32'(want.count),       32'(o_out.count));
                check_field("last",        32'(want.last),        32'(o_out.last));
                words_checked++;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_file();
        test_first_fit_limits();
        test_small_pages();
        test_deep_pages();
        test_mixed_page_sizes();
        test_full_table();
        wait_for_results();
        $display("Sent %0d input words, checked %0d result words, wrote the page size %0d times.",
                 words_sent, words_checked, size_writes);
        $display("Ended with %0d of %0d pages open, %0d inserts turned away, %0d searches hit.",
                 model_pages, MAX_PAGES, inserts_denied, searches_hit);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("PASS heap_file_page_allocator_unit");
        end else begin
            $display("FAIL heap_file_page_allocator_unit");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #20_000_000;
        $display("FAIL heap_file_page_allocator_unit");
        $finish;
    end

endmodule

// File: files.f
hdl/hfpa_pkg.sv
hdl/hfpa_ram.sv
hdl/heap_file_page_allocator_unit.sv
hdl/hfpa_checker.sv
tb/tb.sv
